[hdl/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg: shared constants for the TLS server name extractor
// Buffer sizing, record and handshake codes, and verdict codes.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int BUFFER_SIZE = 4096;

    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 12;
    localparam int WORD_W  = 16;

    // bytes left never exceed total_length, so its width is enough
    localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;
    localparam int LEFT_W    = TOTAL_W;
    localparam logic [LEFT_W-1:0] LEFT_CAP =
        LEFT_W'((BUFFER_SIZE - 1 < TOTAL_MAX) ? BUFFER_SIZE - 1 : TOTAL_MAX);

    localparam logic [BYTE_W-1:0] REC_HANDSHAKE = 8'd22;
    localparam logic [BYTE_W-1:0] HS_CLIENT_HELLO = 8'd1;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;

    localparam logic [WORD_W-1:0] HDR_SKIP_LEN   = 16'd4;
    // handshake length (3) plus version and random (34)
    localparam logic [WORD_W-1:0] HELLO_SKIP_LEN = 16'd37;
    localparam logic [WORD_W-1:0] SNL_SKIP_LEN   = 16'd2;

    localparam logic [1:0] VERDICT_PENDING  = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_NO_NAME  = 2'd2;
    localparam logic [1:0] VERDICT_REJECTED = 2'd3;

endpackage

[hdl/tls_sni_extractor.sv]
// ----------------------------------------------------------------------------
// tls_sni_extractor: byte-serial ClientHello server name extractor
// Walks one peeked TLS record a byte at a time and streams out the host name.
// ----------------------------------------------------------------------------
// One input item (record byte) is taken every clock cycle unless the output
// register is stalled full and the item has a result. An item is held in the
// input register and its result is registered into the output register. The
// field state machine updates its phase and counters once per byte. A result
// is produced for each emitted host name byte and for the item marked tlast,
// which carries the final verdict (1 accepted, 2 no usable name, 3 rejected).
// Records are bounded to 4095 bytes; bytes past the data end read as zero.
// ----------------------------------------------------------------------------
module tls_sni_extractor
    import tse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [19:8] total_length, [23:20] zero
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] name_byte, [9:8] verdict, [15:10] zero
    output logic        m_tuser,   // name_byte_valid
    output logic        m_tlast    // done_res
);

    typedef enum logic [4:0] {
        PH_RTYPE, PH_SKIP_HDR, PH_HTYPE, PH_SKIP_HELLO, PH_SID_LEN, PH_SID_SKIP,
        PH_CS_HI, PH_CS_LO, PH_CS_SKIP, PH_CM_LEN, PH_CM_SKIP, PH_EXT_HI,
        PH_EXT_LO, PH_ET_HI, PH_ET_LO, PH_EL_HI, PH_EL_LO, PH_EXTD_SKIP,
        PH_SNL_SKIP, PH_NT, PH_NL_HI, PH_NL_LO, PH_NAME, PH_FAIL, PH_NAMED
    } phase_t;

    // input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic [TOTAL_W-1:0]  in_total_reg;
    logic                in_last_reg;

    // parser state
    phase_t              ph_reg, ph_next;
    logic [WORD_W-1:0]   skip_reg, skip_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   et_reg, et_next;
    logic                term_reg, term_next;
    logic                bad_reg, bad_next;
    logic                dec_reg, dec_next;

    // output register
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;
    logic                out_user_reg;
    logic                out_last_reg;

    logic                emit;
    logic [BYTE_W-1:0]   name_byte;
    logic                run_finish;
    logic [LEFT_W-1:0]   left_cur;
    logic [WORD_W-1:0]   field_word;
    logic [WORD_W-1:0]   skip_dec;
    logic                produce;
    logic                out_free;
    logic                consume;
    logic [1:0]          verdict;

    assign field_word = {acc_reg[7:0], in_byte_reg};
    assign skip_dec   = skip_reg - 16'd1;
    assign left_cur   = (ph_reg == PH_RTYPE)
                        ? ((in_total_reg[LEFT_W-1:0] > LEFT_CAP) ? LEFT_CAP
                                                                 : in_total_reg[LEFT_W-1:0])
                        : left_reg;

    always_comb
    begin
        ph_next    = ph_reg;
        skip_next  = skip_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        et_next    = et_reg;
        term_next  = term_reg;
        bad_next   = bad_reg;
        dec_next   = dec_reg;
        emit       = 1'b0;
        name_byte  = '0;
        run_finish = 1'b0;

        if (!dec_reg)
        begin
            if (left_cur != '0)
            begin
                left_next = left_cur - LEFT_W'(1);
                case (ph_reg)
                    PH_RTYPE:
                    begin
                        if (in_byte_reg == REC_HANDSHAKE)
                        begin
                            ph_next   = PH_SKIP_HDR;
                            skip_next = HDR_SKIP_LEN;
                        end
                        else
                        begin
                            ph_next  = PH_FAIL;
                            dec_next = 1'b1;
                        end
                    end
                    PH_HTYPE:
                    begin
                        if (in_byte_reg == HS_CLIENT_HELLO)
                        begin
                            ph_next   = PH_SKIP_HELLO;
                            skip_next = HELLO_SKIP_LEN;
                        end
                        else
                        begin
                            ph_next  = PH_FAIL;
                            dec_next = 1'b1;
                        end
                    end
                    PH_SID_LEN:
                    begin
                        if (in_byte_reg == '0)
                            ph_next = PH_CS_HI;
                        else
                        begin
                            ph_next   = PH_SID_SKIP;
                            skip_next = {8'd0, in_byte_reg};
                        end
                    end
                    PH_CM_LEN:
                    begin
                        if (in_byte_reg == '0)
                            ph_next = PH_EXT_HI;
                        else
                        begin
                            ph_next   = PH_CM_SKIP;
                            skip_next = {8'd0, in_byte_reg};
                        end
                    end
                    PH_CS_HI:
                    begin
                        acc_next = {8'd0, in_byte_reg};
                        ph_next  = PH_CS_LO;
                    end
                    PH_EXT_HI:
                    begin
                        acc_next = {8'd0, in_byte_reg};
                        ph_next  = PH_EXT_LO;
                    end
                    PH_ET_HI:
                    begin
                        acc_next = {8'd0, in_byte_reg};
                        ph_next  = PH_ET_LO;
                    end
                    PH_EL_HI:
                    begin
                        acc_next = {8'd0, in_byte_reg};
                        ph_next  = PH_EL_LO;
                    end
                    PH_NL_HI:
                    begin
                        acc_next = {8'd0, in_byte_reg};
                        ph_next  = PH_NL_LO;
                    end
                    PH_CS_LO:
                    begin
                        acc_next = field_word;
                        if (field_word == '0)
                            ph_next = PH_CM_LEN;
                        else
                        begin
                            ph_next   = PH_CS_SKIP;
                            skip_next = field_word;
                        end
                    end
                    PH_EXT_LO:
                    begin
                        acc_next = field_word;
                        // extensions length must fit in what is left
                        if (field_word > {{(WORD_W-LEFT_W){1'b0}}, left_next})
                        begin
                            ph_next  = PH_FAIL;
                            dec_next = 1'b1;
                        end
                        else
                        begin
                            left_next = field_word[LEFT_W-1:0];
                            ph_next   = PH_ET_HI;
                        end
                    end
                    PH_ET_LO:
                    begin
                        et_next = field_word;
                        ph_next = PH_EL_HI;
                    end
                    PH_EL_LO:
                    begin
                        acc_next = field_word;
                        if (et_reg != '0)
                        begin
                            if (field_word == '0)
                                ph_next = PH_ET_HI;
                            else
                            begin
                                ph_next   = PH_EXTD_SKIP;
                                skip_next = field_word;
                            end
                        end
                        else
                        begin
                            ph_next   = PH_SNL_SKIP;
                            skip_next = SNL_SKIP_LEN;
                        end
                    end
                    PH_NT:
                    begin
                        if (in_byte_reg == '0)
                            ph_next = PH_NL_HI;
                        else
                        begin
                            ph_next  = PH_FAIL;
                            dec_next = 1'b1;
                        end
                    end
                    PH_NL_LO:
                    begin
                        acc_next  = field_word;
                        skip_next = field_word;
                        if (field_word == '0)
                        begin
                            ph_next  = PH_NAMED;
                            dec_next = 1'b1;
                        end
                        else
                            ph_next = PH_NAME;
                    end
                    PH_NAME:
                    begin
                        if (!term_reg)
                        begin
                            if (in_byte_reg == '0)
                                term_next = 1'b1;
                            else
                            begin
                                emit      = 1'b1;
                                name_byte = in_byte_reg;
                                if (in_byte_reg == CHAR_SLASH)
                                    bad_next = 1'b1;
                                // leading dot: still at the first name byte
                                if (skip_reg == acc_reg && in_byte_reg == CHAR_DOT)
                                    bad_next = 1'b1;
                            end
                        end
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                        begin
                            ph_next  = PH_NAMED;
                            dec_next = 1'b1;
                        end
                    end
                    PH_SKIP_HDR, PH_SKIP_HELLO, PH_SID_SKIP, PH_CS_SKIP,
                    PH_CM_SKIP, PH_EXTD_SKIP, PH_SNL_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                        begin
                            case (ph_reg)
                                PH_SKIP_HDR:   ph_next = PH_HTYPE;
                                PH_SKIP_HELLO: ph_next = PH_SID_LEN;
                                PH_SID_SKIP:   ph_next = PH_CS_HI;
                                PH_CS_SKIP:    ph_next = PH_CM_LEN;
                                PH_CM_SKIP:    ph_next = PH_EXT_HI;
                                PH_EXTD_SKIP:  ph_next = PH_ET_HI;
                                default:       ph_next = PH_NT;
                            endcase
                        end
                    end
                    default:
                    begin
                        ph_next  = PH_FAIL;
                        dec_next = 1'b1;
                    end
                endcase
                if (!dec_next && left_next == '0)
                    run_finish = 1'b1;
            end
            else
            begin
                left_next  = left_cur;
                run_finish = 1'b1;
            end
        end

        if (in_last_reg && !dec_next)
            run_finish = 1'b1;

        // Data exhausted: the rest reads as zeros. Only a walk already inside
        // the server name extension (or about to enter one) ends with a name.
        if (run_finish)
        begin
            left_next = '0;
            dec_next  = 1'b1;
            case (ph_next)
                PH_SNL_SKIP, PH_NT, PH_NL_HI, PH_NL_LO, PH_NAME:
                    ph_next = PH_NAMED;
                PH_ET_LO:
                    ph_next = (acc_next[7:0] != '0) ? PH_FAIL : PH_NAMED;
                PH_EL_HI, PH_EL_LO:
                    ph_next = (et_next != '0) ? PH_FAIL : PH_NAMED;
                default:
                    ph_next = PH_FAIL;
            endcase
        end
    end

    always_comb
    begin
        if (!in_last_reg)
            verdict = VERDICT_PENDING;
        else if (ph_next == PH_FAIL)
            verdict = VERDICT_NO_NAME;
        else if (bad_next)
            verdict = VERDICT_REJECTED;
        else
            verdict = VERDICT_ACCEPTED;
    end

    assign produce  = emit || in_last_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (out_free || !produce);
    assign s_tready = !in_valid_reg || consume;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_byte_reg   <= '0;
            in_total_reg  <= '0;
            in_last_reg   <= 1'b0;
            ph_reg        <= PH_RTYPE;
            skip_reg      <= '0;
            left_reg      <= '0;
            acc_reg       <= '0;
            et_reg        <= '0;
            term_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata[7:0];
                in_total_reg <= s_tdata[19:8];
                in_last_reg  <= s_tlast;
            end
            else if (consume)
                in_valid_reg <= 1'b0;

            if (consume)
            begin
                if (in_last_reg)
                begin
                    ph_reg   <= PH_RTYPE;
                    skip_reg <= '0;
                    left_reg <= '0;
                    acc_reg  <= '0;
                    et_reg   <= '0;
                    term_reg <= 1'b0;
                    bad_reg  <= 1'b0;
                    dec_reg  <= 1'b0;
                end
                else
                begin
                    ph_reg   <= ph_next;
                    skip_reg <= skip_next;
                    left_reg <= left_next;
                    acc_reg  <= acc_next;
                    et_reg   <= et_next;
                    term_reg <= term_next;
                    bad_reg  <= bad_next;
                    dec_reg  <= dec_next;
                end
            end

            if (consume && produce)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {6'd0, verdict, name_byte};
                out_user_reg  <= emit;
                out_last_reg  <= in_last_reg;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_final_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[9:8] != VERDICT_PENDING)
        else $error("final item without verdict");

    a_mid_needs_name: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[9:8] == VERDICT_PENDING)
        else $error("non-final item without a name byte");

    a_decided_phase: assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg |-> (ph_reg == PH_FAIL || ph_reg == PH_NAMED))
        else $error("decided flag set outside a final phase");

    a_bad_in_name: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg |-> (ph_reg == PH_NAME || ph_reg == PH_NAMED))
        else $error("name rejected outside the name walk");

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |=> ph_reg == PH_RTYPE && !dec_reg && !bad_reg)
        else $error("parser not cleared after the last byte");
`endif

endmodule

[tb/tb_tls_sni_extractor.sv]
// ----------------------------------------------------------------------------
// tb_tls_sni_extractor: self-checking bench for the SNI extractor
// Feeds ClientHello records byte by byte, both well-formed ones with random
// content and broken or random ones. A scoreboard walks each byte through
// its own copy of the field parser and checks every output item in order.
// ----------------------------------------------------------------------------
module tb_tls_sni_extractor;
    import tse_pkg::*;

    typedef enum logic [4:0] {
        W_RTYPE, W_SKIP_HDR, W_HTYPE, W_SKIP_HELLO, W_SID_LEN, W_SID_SKIP,
        W_CS_HI, W_CS_LO, W_CS_SKIP, W_CM_LEN, W_CM_SKIP, W_EXT_HI, W_EXT_LO,
        W_ET_HI, W_ET_LO, W_EL_HI, W_EL_LO, W_EXTD_SKIP, W_SNL_SKIP, W_NT,
        W_NL_HI, W_NL_LO, W_NAME, W_FAIL, W_NAMED
    } walk_phase_t;

    typedef struct {
        logic [7:0] name_byte;
        logic       name_valid;
        logic       done;
        logic [1:0] verdict;
    } sni_result_t;

    class sni_scoreboard;
        sni_result_t expected_q[$];
        int          errors;

        walk_phase_t walk;
        logic [15:0] skip_left;
        int unsigned data_left;
        logic [15:0] word_acc;
        logic [15:0] ext_kind;
        bit          host_ended;
        bit          host_bad;
        bit          settled;
        bit          emit_valid;
        logic [7:0]  emit_byte;

        function new();
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            walk       = W_RTYPE;
            skip_left  = '0;
            data_left  = 0;
            word_acc   = '0;
            ext_kind   = '0;
            host_ended = 1'b0;
            host_bad   = 1'b0;
            settled    = 1'b0;
        endfunction

        function walk_phase_t skip_exit(walk_phase_t p);
            case (p)
                W_SKIP_HDR:   return W_HTYPE;
                W_SKIP_HELLO: return W_SID_LEN;
                W_SID_SKIP:   return W_CS_HI;
                W_CS_SKIP:    return W_CM_LEN;
                W_CM_SKIP:    return W_EXT_HI;
                W_EXTD_SKIP:  return W_ET_HI;
                default:      return W_NT;
            endcase
        endfunction

        function bit is_skip(walk_phase_t p);
            return p == W_SKIP_HDR || p == W_SKIP_HELLO || p == W_SID_SKIP ||
                   p == W_CS_SKIP || p == W_CM_SKIP || p == W_EXTD_SKIP ||
                   p == W_SNL_SKIP;
        endfunction

        function void start_skip(walk_phase_t p, logic [15:0] n);
            if (n == 0)
                walk = skip_exit(p);
            else
            begin
                walk      = p;
                skip_left = n;
            end
        endfunction

        function void reject();
            walk    = W_FAIL;
            settled = 1'b1;
        endfunction

        function void close_name();
            walk    = W_NAMED;
            settled = 1'b1;
        endfunction

        function void parse(logic [7:0] b);
            case (walk)
                W_RTYPE:
                    if (b == REC_HANDSHAKE) start_skip(W_SKIP_HDR, HDR_SKIP_LEN);
                    else reject();
                W_HTYPE:
                    if (b == HS_CLIENT_HELLO) start_skip(W_SKIP_HELLO, HELLO_SKIP_LEN);
                    else reject();
                W_SID_LEN: start_skip(W_SID_SKIP, {8'd0, b});
                W_CM_LEN:  start_skip(W_CM_SKIP, {8'd0, b});
                W_CS_HI:
                begin
                    word_acc = {8'd0, b};
                    walk     = W_CS_LO;
                end
                W_EXT_HI:
                begin
                    word_acc = {8'd0, b};
                    walk     = W_EXT_LO;
                end
                W_ET_HI:
                begin
                    word_acc = {8'd0, b};
                    walk     = W_ET_LO;
                end
                W_EL_HI:
                begin
                    word_acc = {8'd0, b};
                    walk     = W_EL_LO;
                end
                W_NL_HI:
                begin
                    word_acc = {8'd0, b};
                    walk     = W_NL_LO;
                end
                W_CS_LO:
                begin
                    word_acc = {word_acc[7:0], b};
                    start_skip(W_CS_SKIP, word_acc);
                end
                W_EXT_LO:
                begin
                    word_acc = {word_acc[7:0], b};
                    // extensions length bounds the rest of the record
                    if (32'(word_acc) > data_left)
                        reject();
                    else
                    begin
                        data_left = 32'(word_acc);
                        walk      = W_ET_HI;
                    end
                end
                W_ET_LO:
                begin
                    ext_kind = {word_acc[7:0], b};
                    walk     = W_EL_HI;
                end
                W_EL_LO:
                begin
                    word_acc = {word_acc[7:0], b};
                    if (ext_kind != 0) start_skip(W_EXTD_SKIP, word_acc);
                    else start_skip(W_SNL_SKIP, SNL_SKIP_LEN);
                end
                W_NT:
                    if (b == 0) walk = W_NL_HI;
                    else reject();
                W_NL_LO:
                begin
                    word_acc  = {word_acc[7:0], b};
                    skip_left = word_acc;
                    if (word_acc == 0) close_name();
                    else walk = W_NAME;
                end
                W_NAME:
                begin
                    if (!host_ended)
                    begin
                        if (b == 0)
                            host_ended = 1'b1;
                        else
                        begin
                            emit_valid = 1'b1;
                            emit_byte  = b;
                            if (b == CHAR_SLASH) host_bad = 1'b1;
                            if (skip_left == word_acc && b == CHAR_DOT) host_bad = 1'b1;
                        end
                    end
                    if (skip_left > 0) skip_left--;
                    if (skip_left == 0) close_name();
                end
                default:
                    if (is_skip(walk))
                    begin
                        if (skip_left > 0) skip_left--;
                        if (skip_left == 0) walk = skip_exit(walk);
                    end
                    else
                        reject();
            endcase
        endfunction

        // data exhausted: zero reads, skips collapse, outcome settles at once
        function void run_out();
            data_left = 0;
            while (!settled)
            begin
                if (is_skip(walk))
                begin
                    skip_left = '0;
                    walk      = skip_exit(walk);
                end
                else if (walk == W_ET_HI)
                    reject();
                else if (walk == W_NAME)
                    close_name();
                else
                    parse(8'd0);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic [11:0] total, logic last);
            sni_result_t r;
            emit_valid = 1'b0;
            emit_byte  = '0;
            if (!settled)
            begin
                if (walk == W_RTYPE)
                    data_left = (total < LEFT_CAP) ? 32'(total) : 32'(LEFT_CAP);
                if (data_left > 0)
                begin
                    data_left--;
                    parse(b);
                    if (!settled && data_left == 0) run_out();
                end
                else
                    run_out();
            end
            if (last && !settled) run_out();
            if (!emit_valid && !last) return;
            r.name_byte  = emit_byte;
            r.name_valid = emit_valid;
            r.done       = last;
            if (!last)
                r.verdict = VERDICT_PENDING;
            else if (walk == W_FAIL)
                r.verdict = VERDICT_NO_NAME;
            else if (host_bad)
                r.verdict = VERDICT_REJECTED;
            else
                r.verdict = VERDICT_ACCEPTED;
            expected_q.push_back(r);
            if (last) clear_walk();
        endfunction

        function void check_result(logic [7:0] nb, logic nv, logic dn, logic [1:0] vd);
            sni_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected item: name_byte %0h valid %0b done %0b verdict %0d",
                       nb, nv, dn, vd);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (nb !== e.name_byte)
            begin
                $error("name_byte: expected %0h, actual %0h", e.name_byte, nb);
                errors++;
            end
            if (nv !== e.name_valid)
            begin
                $error("name_byte_valid: expected %0b, actual %0b", e.name_valid, nv);
                errors++;
            end
            if (dn !== e.done)
            begin
                $error("done_res: expected %0b, actual %0b", e.done, dn);
                errors++;
            end
            if (vd !== e.verdict)
            begin
                $error("verdict: expected %0d, actual %0d", e.verdict, vd);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] data_byte, [19:8] total_length, [23:20] zero
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] name_byte, [9:8] verdict, [15:10] zero
    logic        m_tuser;   // name_byte_valid
    logic        m_tlast;   // done_res

    sni_scoreboard sb;
    int            send_idle;
    int            recv_stall;
    int            hold_left;
    int            items_sent;
    logic [7:0]    rec_q[$];
    logic [7:0]    ext_q[$];
    logic [7:0]    host_q[$];

    tls_sni_extractor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls plus a single long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // outputs are stable mid-cycle; an item moves at the next rising edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata[7:0], m_tuser, m_tlast, m_tdata[9:8]);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [11:0] total, input logic last);
        bit took;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, total, b};
        s_tlast  <= last;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = s_tready;
            if (took) sb.note_byte(b, total, last);
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_record(input logic [11:0] total);
        for (int i = 0; i < rec_q.size(); i++)
            send_byte(rec_q[i], total, i == rec_q.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_host(input string s);
        host_q.delete();
        for (int i = 0; i < s.len(); i++)
            host_q.push_back(s[i]);
    endtask

    task automatic fill_host(input int n);
        int r;
        host_q.delete();
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 60)      host_q.push_back(8'h61 + 8'($urandom_range(25)));
            else if (r < 75) host_q.push_back(8'h30 + 8'($urandom_range(9)));
            else if (r < 88) host_q.push_back(CHAR_DOT);
            else if (r < 93) host_q.push_back(8'h2d);
            else if (r < 96) host_q.push_back(CHAR_SLASH);
            else if (r < 98) host_q.push_back(8'h00);
            else             host_q.push_back(8'($urandom_range(255)));
        end
        if (n > 0 && $urandom_range(9) == 0) host_q[0] = CHAR_DOT;
    endtask

    task automatic add_other_ext();
        int n;
        n = $urandom_range(0, 6);
        ext_q.push_back(8'($urandom_range(255)));
        ext_q.push_back(8'($urandom_range(1, 255)));   // type never zero
        ext_q.push_back(8'd0);
        ext_q.push_back(8'(n));
        repeat (n) ext_q.push_back(8'($urandom_range(255)));
    endtask

    // ClientHello, with the server name extension built from host_q when with_sni is set
    task automatic build_hello(input int n_sid, input int n_cs, input int n_cm,
                               input int n_pre, input bit with_sni,
                               input logic [7:0] ntype, input int name_len,
                               input int n_post, input int ext_adj);
        int ext_len;
        rec_q.delete();
        ext_q.delete();
        rec_q.push_back(REC_HANDSHAKE);
        repeat (4) rec_q.push_back(8'($urandom_range(255)));
        rec_q.push_back(HS_CLIENT_HELLO);
        repeat (37) rec_q.push_back(8'($urandom_range(255)));
        rec_q.push_back(8'(n_sid));
        repeat (n_sid) rec_q.push_back(8'($urandom_range(255)));
        rec_q.push_back(8'(n_cs >> 8));
        rec_q.push_back(8'(n_cs));
        repeat (n_cs) rec_q.push_back(8'($urandom_range(255)));
        rec_q.push_back(8'(n_cm));
        repeat (n_cm) rec_q.push_back(8'($urandom_range(255)));
        repeat (n_pre) add_other_ext();
        if (with_sni)
        begin
            ext_q.push_back(8'd0);
            ext_q.push_back(8'd0);
            ext_q.push_back(8'((host_q.size() + 5) >> 8));
            ext_q.push_back(8'(host_q.size() + 5));
            ext_q.push_back(8'((host_q.size() + 3) >> 8));
            ext_q.push_back(8'(host_q.size() + 3));
            ext_q.push_back(ntype);
            ext_q.push_back(8'(name_len >> 8));
            ext_q.push_back(8'(name_len));
            foreach (host_q[i]) ext_q.push_back(host_q[i]);
        end
        repeat (n_post) add_other_ext();
        ext_len = ext_q.size() + ext_adj;
        if (ext_len < 0) ext_len = 0;
        if (ext_len > 65535) ext_len = 65535;
        rec_q.push_back(8'(ext_len >> 8));
        rec_q.push_back(8'(ext_len));
        foreach (ext_q[i]) rec_q.push_back(ext_q[i]);
    endtask

    task automatic make_random_record(output logic [11:0] total);
        int r;
        int pick;
        int name_len;
        int ext_adj;
        r = $urandom_range(99);
        if (r < 12)
        begin
            rec_q.delete();
            repeat ($urandom_range(1, 8)) rec_q.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) rec_q[0] = REC_HANDSHAKE;
            total = 12'($urandom_range(4095));
            return;
        end
        fill_host($urandom_range(0, 12));
        pick = $urandom_range(9);
        if (pick < 7)      name_len = host_q.size();
        else if (pick < 9) name_len = host_q.size() + $urandom_range(1, 6);
        else               name_len = $urandom_range(65535);
        pick = $urandom_range(9);
        if (pick < 7)      ext_adj = 0;
        else if (pick < 8) ext_adj = -$urandom_range(1, 6);
        else if (pick < 9) ext_adj = $urandom_range(1, 8);
        else               ext_adj = $urandom_range(65535);
        build_hello($urandom_range(0, 8), 2 * $urandom_range(1, 4), $urandom_range(1, 2),
                    $urandom_range(0, 2), $urandom_range(9) != 0,
                    ($urandom_range(15) == 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                    name_len, $urandom_range(0, 2), ext_adj);
        pick = $urandom_range(19);
        if (pick == 0)      total = 12'd4095;
        else if (pick == 1) total = 12'($urandom_range(rec_q.size(), 4095));
        else                total = 12'(rec_q.size());
        if (r < 27)
        begin
            case ($urandom_range(2))
                0: rec_q[$urandom_range(rec_q.size() - 1)] = 8'($urandom_range(255));
                1:
                begin
                    // short message: may end before total_length
                    pick = $urandom_range(1, rec_q.size());
                    while (rec_q.size() > pick) void'(rec_q.pop_back());
                end
                default: repeat ($urandom_range(1, 6)) rec_q.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic run_random(input int n_items);
        logic [11:0] total;
        int          stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            make_random_record(total);
            send_record(total);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        hold_left  = 0;
        items_sent = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed records, no idling
        set_host("host.test");
        build_hello(2, 2, 1, 1, 1'b1, 8'd0, host_q.size(), 1, 0);
        send_record(12'(rec_q.size()));
        set_host(".lead");
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, host_q.size(), 0, 0);
        send_record(12'(rec_q.size()));
        set_host("a/b");
        build_hello(1, 4, 1, 0, 1'b1, 8'd0, host_q.size(), 0, 0);
        send_record(12'(rec_q.size()));
        // slash after a zero byte is never looked at
        set_host("ab");
        host_q.push_back(8'h00);
        host_q.push_back(CHAR_SLASH);
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, host_q.size(), 0, 0);
        send_record(12'(rec_q.size()));
        host_q.delete();
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, 0, 1, 0);
        send_record(12'(rec_q.size()));
        build_hello(0, 2, 1, 2, 1'b0, 8'd0, 0, 0, 0);
        send_record(12'(rec_q.size()));
        rec_q = '{8'h17};
        send_record(12'd1);
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, 0, 0, 0);
        rec_q[5] = 8'h02;
        send_record(12'(rec_q.size()));
        set_host("over");
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, host_q.size(), 0, 20);
        send_record(12'(rec_q.size()));
        rec_q = '{REC_HANDSHAKE, 8'h00, 8'hff};
        send_record(12'd0);
        // name length beyond the extensions bound, record ends before total
        set_host("short");
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, 40, 1, 0);
        send_record(12'd4095);
        set_host("kind");
        build_hello(0, 2, 1, 0, 1'b1, 8'h01, host_q.size(), 0, 0);
        send_record(12'(rec_q.size()));
        set_host("tail");
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, host_q.size(), 0, 0);
        begin
            logic [11:0] real_len;
            real_len = 12'(rec_q.size());
            repeat (6) rec_q.push_back(8'hff);
            send_record(real_len);
        end
        host_q = '{8'hff, 8'h80, 8'h7f};
        build_hello(0, 2, 1, 0, 1'b1, 8'd0, host_q.size(), 0, 0);
        send_record(12'(rec_q.size()));
        wait_drained();

        // random records; long output hold-off during the first stretch
        fork
            run_random(100);
            begin
                repeat (40) @(negedge clk);
                hold_left = 300;
            end
        join
        wait_drained();
        send_idle  = 59;
        recv_stall = 0;
        run_random(100);
        wait_drained();
        send_idle  = 0;
        recv_stall = 59;
        run_random(100);
        wait_drained();
        send_idle  = 32;
        recv_stall = 32;
        run_random(100);
        wait_drained();

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hdl/tse_pkg.sv
hdl/tls_sni_extractor.sv
tb/tb_tls_sni_extractor.sv
